// File: src/sha256mh_pkg.sv
`default_nettype none

package sha256mh_pkg;

  localparam int unsigned ROUNDS  = 64;
  localparam int unsigned RND_W   = $clog2(ROUNDS);
  localparam int unsigned CNT_W   = 61;
  localparam int unsigned FILL_W  = 6;
  localparam int unsigned WIDX_W  = 2;

  localparam logic [RND_W-1:0]  RND_LAST   = RND_W'(ROUNDS - 1);
  localparam logic [FILL_W-1:0] FILL_LAST  = 6'd63;
  localparam logic [FILL_W-1:0] FILL_LEN   = 6'd56;
  localparam logic [WIDX_W-1:0] WIDX_LAST  = 2'd3;
  localparam logic [7:0]        PAD_BYTE   = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_FIN,
    ST_PAD80,
    ST_PADZ,
    ST_PADLEN,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SEL_IN,
    SEL_PAD,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic             shift_en;
    byte_sel_t        byte_sel;
    logic             count_en;
    logic             load_vars;
    logic             round_en;
    logic [RND_W-1:0] round_idx;
    logic             add_chain;
    logic             emit_load;
    logic             restart;
  } cmd_t;

  typedef struct packed {
    logic fill_full;
    logic fill_len;
  } sts_t;

  function automatic logic [31:0] init_h(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      3'd7: v = 32'h5be0cd19;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [RND_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
      6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
      6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
      6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
      6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
      6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
      6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
      6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
      6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
      6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
      6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
      6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
      6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
      6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
      6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
      6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
      6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
      6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
      6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
      6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
      6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

// File: src/sha256mh_in_if.sv
`default_nettype none

interface sha256mh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, output data_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

`default_nettype wire

// File: src/sha256mh_out_if.sv
`default_nettype none

interface sha256mh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

`default_nettype wire

// File: src/sha256mh_ctrl.sv
`default_nettype none

module sha256mh_ctrl
  import sha256mh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_byte_present,
  input  logic              in_end_of_message,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [WIDX_W-1:0] out_word_index,
  output logic              out_last_word,
  input  sts_t              sts,
  output cmd_t              cmd
);

  state_t            state_r, state_nxt;
  state_t            ret_r, ret_nxt;
  logic [RND_W-1:0]  rnd_r, rnd_nxt;
  logic [WIDX_W-1:0] widx_r, widx_nxt;
  logic [WIDX_W-1:0] oidx_r, oidx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;
  logic              out_load;

  assign accept = in_valid && in_ready;

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.byte_sel = SEL_IN;
    cmd.round_idx = rnd_r;
    in_ready     = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.shift_en = in_valid && in_byte_present;
        cmd.count_en = in_valid && in_byte_present;
        cmd.load_vars = in_valid && in_byte_present && sts.fill_full;
      end
      ST_COMP: begin
        cmd.round_en = 1'b1;
      end
      ST_FIN: begin
        cmd.add_chain = 1'b1;
      end
      ST_PAD80: begin
        cmd.shift_en  = 1'b1;
        cmd.byte_sel  = SEL_PAD;
        cmd.load_vars = sts.fill_full;
      end
      ST_PADZ: begin
        cmd.shift_en  = !sts.fill_len;
        cmd.byte_sel  = SEL_ZERO;
        cmd.load_vars = !sts.fill_len && sts.fill_full;
      end
      ST_PADLEN: begin
        cmd.shift_en  = 1'b1;
        cmd.byte_sel  = SEL_LEN;
        cmd.load_vars = sts.fill_full;
      end
      ST_EMIT: begin
        out_load      = !out_valid_r || out_ready;
        cmd.emit_load = out_load;
        cmd.restart   = out_load && (widx_r == WIDX_LAST);
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    rnd_nxt       = rnd_r;
    widx_nxt      = widx_r;
    oidx_nxt      = oidx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_byte_present && sts.fill_full) begin
            state_nxt = ST_COMP;
            ret_nxt   = in_end_of_message ? ST_PAD80 : ST_IDLE;
          end else if (in_end_of_message) begin
            state_nxt = ST_PAD80;
          end
        end
      end
      ST_COMP: begin
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == RND_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        state_nxt = ret_r;
      end
      ST_PAD80: begin
        if (sts.fill_full) begin
          state_nxt = ST_COMP;
          ret_nxt   = ST_PADZ;
        end else begin
          state_nxt = ST_PADZ;
        end
      end
      ST_PADZ: begin
        if (sts.fill_len) begin
          state_nxt = ST_PADLEN;
        end else if (sts.fill_full) begin
          state_nxt = ST_COMP;
          ret_nxt   = ST_PADZ;
        end
      end
      ST_PADLEN: begin
        if (sts.fill_full) begin
          state_nxt = ST_COMP;
          ret_nxt   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          oidx_nxt      = widx_r;
          widx_nxt      = widx_r + 1'b1;
          if (widx_r == WIDX_LAST) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      rnd_r       <= '0;
      widx_r      <= '0;
      oidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      rnd_r       <= rnd_nxt;
      widx_r      <= widx_nxt;
      oidx_r      <= oidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_word_index = oidx_r;
  assign out_last_word  = (oidx_r == WIDX_LAST);

  a_fin_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> ($past(state_r) == ST_COMP && $past(rnd_r) == RND_LAST))
    else $error("chaining add without a full set of rounds");

  a_round_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_COMP) |-> (rnd_r == '0))
    else $error("round counter not parked outside compression");

  a_no_shift_in_round: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.round_en && cmd.shift_en))
    else $error("byte shift during a round");

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_load && widx_r == WIDX_LAST) |=>
      (state_r == ST_IDLE && out_valid_r && out_last_word))
    else $error("final digest word not presented");

endmodule

`default_nettype wire

// File: src/sha256mh_datapath.sv
`default_nettype none

module sha256mh_datapath
  import sha256mh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic [7:0]  in_data_byte,
  output sts_t        sts,
  output logic [63:0] out_digest_word
);

  // block buffer doubles as the rolling schedule window, word 0 at the top
  logic [511:0]       blk_r, blk_nxt;
  logic [31:0]        chain_r [8];
  logic [31:0]        chain_nxt [8];
  logic [31:0]        var_r [8];
  logic [31:0]        var_nxt [8];
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [63:0]        digest_r, digest_nxt;

  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] t1, t2;
  logic [63:0] bit_len, len_sh;
  logic [7:0]  byte_in;

  assign w0  = blk_r[511:480];
  assign w1  = blk_r[479:448];
  assign w9  = blk_r[223:192];
  assign w14 = blk_r[63:32];
  assign w_new = ssig1(w14) + w9 + ssig0(w1) + w0;

  assign t1 = var_r[7] + bsig1(var_r[4]) + ((var_r[4] & var_r[5]) ^ (~var_r[4] & var_r[6]))
              + round_k(cmd.round_idx) + w0;
  assign t2 = bsig0(var_r[0]) +
              ((var_r[0] & var_r[1]) ^ (var_r[0] & var_r[2]) ^ (var_r[1] & var_r[2]));

  // length bytes go out most significant first as fill runs from 56 to 63
  assign bit_len = {count_r, 3'b000};
  assign len_sh  = bit_len >> {~fill_r[2:0], 3'b000};

  always_comb begin
    case (cmd.byte_sel)
      SEL_IN:   byte_in = in_data_byte;
      SEL_PAD:  byte_in = PAD_BYTE;
      SEL_ZERO: byte_in = 8'h00;
      SEL_LEN:  byte_in = len_sh[7:0];
      default:  byte_in = 8'h00;
    endcase
  end

  always_comb begin
    blk_nxt    = blk_r;
    fill_nxt   = fill_r;
    count_nxt  = count_r;
    digest_nxt = digest_r;
    chain_nxt  = chain_r;
    var_nxt    = var_r;

    if (cmd.round_en) begin
      blk_nxt = {blk_r[479:0], w_new};
    end else if (cmd.shift_en) begin
      blk_nxt  = {blk_r[503:0], byte_in};
      fill_nxt = fill_r + 1'b1;
    end

    if (cmd.restart) begin
      count_nxt = '0;
    end else if (cmd.count_en) begin
      count_nxt = count_r + 1'b1;
    end

    if (cmd.load_vars) begin
      var_nxt = chain_r;
    end else if (cmd.round_en) begin
      var_nxt[7] = var_r[6];
      var_nxt[6] = var_r[5];
      var_nxt[5] = var_r[4];
      var_nxt[4] = var_r[3] + t1;
      var_nxt[3] = var_r[2];
      var_nxt[2] = var_r[1];
      var_nxt[1] = var_r[0];
      var_nxt[0] = t1 + t2;
    end

    if (cmd.emit_load) begin
      digest_nxt = {chain_r[0], chain_r[1]};
    end

    if (cmd.restart) begin
      for (int i = 0; i < 8; i++) begin
        chain_nxt[i] = init_h(3'(i));
      end
    end else if (cmd.add_chain) begin
      for (int i = 0; i < 8; i++) begin
        chain_nxt[i] = chain_r[i] + var_r[i];
      end
    end else if (cmd.emit_load) begin
      // rotate two words so the next pair sits at the front
      for (int i = 0; i < 8; i++) begin
        chain_nxt[i] = chain_r[(i + 2) % 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      count_r <= '0;
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= init_h(3'(i));
      end
    end else begin
      fill_r  <= fill_nxt;
      count_r <= count_nxt;
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r    <= blk_nxt;
    var_r    <= var_nxt;
    digest_r <= digest_nxt;
  end

  assign sts.fill_full   = (fill_r == FILL_LAST);
  assign sts.fill_len    = (fill_r == FILL_LEN);
  assign out_digest_word = digest_r;

endmodule

`default_nettype wire

// File: src/sha256_message_hasher_unit.sv
`default_nettype none

// channel    dir   payload                                      transaction
// in_chan    in    data_byte[7:0] byte_present end_of_message   valid & ready
// out_chan   out   digest_word[63:0] word_index[1:0] last_word  valid & ready
//
// bytes are taken back to back while idle; every 64th byte then holds input off
// for a compression (64 rounds of the shared round unit plus the chaining add)
// end of message: padding shifts one byte a cycle to the block end, then one or two
// compressions, then four output words at one a cycle when not stalled
// rst_n is synchronous, active low; no clearing pass, ready in the first cycle after
// in_chan.ready is high only while idle; a stalled output word holds in its register

module sha256_message_hasher_unit
  import sha256mh_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  sha256mh_in_if.sink     in_chan,
  sha256mh_out_if.source  out_chan
);

  cmd_t cmd;
  sts_t sts;

  sha256mh_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_chan.valid),
    .in_byte_present   (in_chan.byte_present),
    .in_end_of_message (in_chan.end_of_message),
    .in_ready          (in_chan.ready),
    .out_ready         (out_chan.ready),
    .out_valid         (out_chan.valid),
    .out_word_index    (out_chan.word_index),
    .out_last_word     (out_chan.last_word),
    .sts               (sts),
    .cmd               (cmd)
  );

  sha256mh_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_data_byte    (in_chan.data_byte),
    .sts             (sts),
    .out_digest_word (out_chan.digest_word)
  );

endmodule

`default_nettype wire

// File: sim/sha256_digest_checker.sv
`timescale 1ns / 1ps

module sha256_digest_checker
  import sha256mh_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  sha256mh_in_if  in_mon,
  sha256mh_out_if out_mon,
  output int      failures,
  output int      words_pending
);

  localparam logic [0:63][31:0] ROUND_CONST = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [0:7][31:0] START_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [63:0] word;
    logic [1:0]  idx;
    logic        last;
  } digest_beat_t;

  logic [31:0]  chain_h [8];
  logic [7:0]   msg_block [64];
  logic [5:0]   fill;
  logic [60:0]  byte_count;
  digest_beat_t digest_q [$];

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void run_rounds();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 0; i < 8; i++)
      v[i] = chain_h[i];
    for (int i = 0; i < 64; i++) begin
      if (i >= 16) begin
        s0 = rotr(w[(i+1)%16], 7) ^ rotr(w[(i+1)%16], 18) ^ (w[(i+1)%16] >> 3);
        s1 = rotr(w[(i+14)%16], 17) ^ rotr(w[(i+14)%16], 19) ^ (w[(i+14)%16] >> 10);
        w[i%16] = w[i%16] + s0 + w[(i+9)%16] + s1;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + w[i%16];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++)
      chain_h[i] = chain_h[i] + v[i];
  endfunction

  function automatic void begin_message();
    for (int i = 0; i < 8; i++)
      chain_h[i] = START_HASH[i];
    fill = '0;
    byte_count = '0;
  endfunction

  function automatic void close_message();
    int          pos;
    logic [63:0] bit_len;
    pos = int'(fill);
    msg_block[pos] = PAD_BYTE;
    pos++;
    // no room left for the length field, so it goes in an extra block
    if (pos > 56) begin
      while (pos < 64) begin
        msg_block[pos] = 8'h00;
        pos++;
      end
      run_rounds();
      pos = 0;
    end
    while (pos < 56) begin
      msg_block[pos] = 8'h00;
      pos++;
    end
    bit_len = {byte_count, 3'b000};
    for (int k = 0; k < 8; k++)
      msg_block[63-k] = bit_len[8*k +: 8];
    run_rounds();
    for (int k = 0; k < 4; k++)
      digest_q.push_back(digest_beat_t'{word: {chain_h[2*k], chain_h[2*k+1]},
                                        idx: 2'(k), last: (2'(k) == WIDX_LAST)});
    begin_message();
  endfunction

  always @(posedge clk) begin
    digest_beat_t want;
    if (!rst_n) begin
      begin_message();
      digest_q.delete();
      failures = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (digest_q.size() == 0) begin
          $error("digest word %h arrived with none expected", out_mon.digest_word);
          failures++;
        end else begin
          want = digest_q.pop_front();
          if (out_mon.digest_word !== want.word) begin
            $error("digest_word: expected %h, got %h", want.word, out_mon.digest_word);
            failures++;
          end
          if (out_mon.word_index !== want.idx) begin
            $error("word_index: expected %0d, got %0d", want.idx, out_mon.word_index);
            failures++;
          end
          if (out_mon.last_word !== want.last) begin
            $error("last_word: expected %0b, got %0b", want.last, out_mon.last_word);
            failures++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.byte_present) begin
          msg_block[fill] = in_mon.data_byte;
          fill = fill + 1'b1;
          byte_count = byte_count + 1'b1;
          if (fill == '0)
            run_rounds();
        end
        if (in_mon.end_of_message)
          close_message();
      end
    end
    words_pending = digest_q.size();
  end

endmodule

// File: sim/sha256_message_hasher_unit_test.sv
`timescale 1ns / 1ps

module sha256_message_hasher_unit_test;

  localparam int QUIET_LIMIT = 4000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_words;
  int   src_idle_pct;
  int   sink_stall_pct;
  int   quiet_cycles;

  sha256mh_in_if  in_chan ();
  sha256mh_out_if out_chan ();

  sha256_message_hasher_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  sha256_digest_checker digest_watch (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .failures      (fail_count),
    .words_pending (pending_words)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic present, input logic last);
    logic taken;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.data_byte      <= b;
    in_chan.byte_present   <= present;
    in_chan.end_of_message <= last;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = in_chan.ready;
      @(negedge clk);
    end
  endtask

  // end mark either rides on the final byte or follows as an empty item
  task automatic send_message(input int len);
    logic split_end;
    split_end = (len == 0) || ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0)
        send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, !split_end && (i == len - 1));
    end
    if (split_end)
      send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int long_len;
    int n_short;
    in_chan.valid          = 1'b0;
    in_chan.data_byte      = 8'h00;
    in_chan.byte_present   = 1'b0;
    in_chan.end_of_message = 1'b0;
    out_chan.ready         = 1'b0;
    rst_n                  = 1'b0;
    src_idle_pct           = 0;
    sink_stall_pct         = 0;
    quiet_cycles           = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // empty message straight after reset
    send_item(8'hA5, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h3C, 1'b0, 1'b0);
    send_item(8'hC3, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
          long_len = 64;
          n_short = 0;
        end
        1: begin
          src_idle_pct = 45;
          sink_stall_pct = 0;
          long_len = $urandom_range(0, 4);
          n_short = 2;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 45;
          long_len = $urandom_range(0, 4);
          n_short = 2;
        end
        default: begin
          src_idle_pct = 12;
          sink_stall_pct = 12;
          long_len = 56;
          n_short = 0;
        end
      endcase
      send_message(long_len);
      repeat (n_short) send_message($urandom_range(0, 4));
    end
    in_chan.valid <= 1'b0;

    while (pending_words != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: sha256_message_hasher_unit.f
src/sha256mh_pkg.sv
src/sha256mh_in_if.sv
src/sha256mh_out_if.sv
src/sha256mh_ctrl.sv
src/sha256mh_datapath.sv
src/sha256_message_hasher_unit.sv
sim/sha256_digest_checker.sv
sim/sha256_message_hasher_unit_test.sv
